// ----- sv/lmft_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lmft_pkg
// Types, constants and the bandwidth lookup shared by the MIB field tracker.
// ----------------------------------------------------------------------------
package lmft_pkg;

	localparam int unsigned MibW   = 24;
	localparam int unsigned AntW   = 3;
	localparam int unsigned TagW   = 4;
	localparam int unsigned RbW    = 7;
	localparam int unsigned ResW   = 2;
	localparam int unsigned SfnW   = 10;
	localparam int unsigned CountW = 8;

	localparam logic [CountW-1:0] AcceptLimitReset = CountW'(10);
	localparam logic [CountW-1:0] CountMax         = {CountW{1'b1}};

	typedef enum logic {
		KIND_STATE = 1'b0,
		KIND_FRAME = 1'b1
	} kind_t;

	typedef enum logic [2:0] {
		BW_IDX_6   = 3'd0,
		BW_IDX_15  = 3'd1,
		BW_IDX_25  = 3'd2,
		BW_IDX_50  = 3'd3,
		BW_IDX_75  = 3'd4,
		BW_IDX_100 = 3'd5
	} bw_idx_t;

	typedef struct packed {
		logic [MibW-1:0] mib_bits;
		logic [AntW-1:0] antenna_count;
		logic            tag_present;
		logic [TagW-1:0] tag_index;
	} item_t;

	typedef struct packed {
		logic [AntW-1:0]   ant_ports;
		logic              cell_valid;
		logic [RbW-1:0]    bandwidth;
		logic              phich_long;
		logic [ResW-1:0]   phich_grp;
		logic [CountW-1:0] unchanged_count;
		logic              frame_valid;
		logic [SfnW-1:0]   frame;
	} cell_state_t;

	typedef struct packed {
		kind_t           kind;
		logic [AntW-1:0] ant_ports;
		logic [RbW-1:0]  bandwidth_rb;
		logic            phich_long;
		logic [ResW-1:0] phich_res_code;
		logic [SfnW-1:0] frame_number;
		logic            last;
	} result_t;

	function automatic logic [RbW-1:0] rb_lookup(input logic [2:0] idx);
		logic [RbW-1:0] rb;
		unique case (idx)
			BW_IDX_6:   rb = RbW'(6);
			BW_IDX_15:  rb = RbW'(15);
			BW_IDX_25:  rb = RbW'(25);
			BW_IDX_50:  rb = RbW'(50);
			BW_IDX_75:  rb = RbW'(75);
			BW_IDX_100: rb = RbW'(100);
			default:    rb = '0;
		endcase
		return rb;
	endfunction

endpackage
`default_nettype wire

// ----- sv/lte_mib_field_tracker_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lte_mib_field_tracker_top
// Tracks LTE MIB cell state and system frame number, reporting changes.
// ----------------------------------------------------------------------------
// Path: input register, then report register. Throughput: one MIB word per
// cycle unless stalled; the decode and the state update sit in one stage
// between the input register and the report register.
// Stall: a reporting word waits while an earlier report word is held.
// Reset: clears all held state and the pipeline, and sets accept_limit to 10.
// Each MIB word gives at most one report word.
// ----------------------------------------------------------------------------
module lte_mib_field_tracker_top (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_wr_en,
	input  wire logic [lmft_pkg::CountW-1:0]   cfg_wr_data,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [lmft_pkg::MibW-1:0]     mib_bits,
	input  wire logic [lmft_pkg::AntW-1:0]     antenna_count,
	input  wire logic                          tag_present,
	input  wire logic [lmft_pkg::TagW-1:0]     tag_index,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic                               kind,
	output logic [lmft_pkg::AntW-1:0]          ant_ports,
	output logic [lmft_pkg::RbW-1:0]           bandwidth_rb,
	output logic                               phich_long,
	output logic [lmft_pkg::ResW-1:0]          phich_res_code,
	output logic [lmft_pkg::SfnW-1:0]          frame_number,
	output logic                               last
);
	import lmft_pkg::*;

	logic [CountW-1:0] accept_limit_q;
	logic              valid_s1;
	item_t             item_s1;
	cell_state_t       state_q;
	cell_state_t       state_nxt;
	logic              emit;
	result_t           res;
	logic              out_valid_q;
	result_t           out_q;
	logic              slot_free;
	logic              advance;

	lmft_step u_step (
		.item         (item_s1),
		.cur          (state_q),
		.accept_limit (accept_limit_q),
		.nxt          (state_nxt),
		.emit         (emit),
		.res          (res)
	);

	assign slot_free = !out_valid_q || out_ready;
	assign advance   = valid_s1 && (!emit || slot_free);
	assign in_ready  = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accept_limit_q <= AcceptLimitReset;
		end else if (cfg_wr_en) begin
			accept_limit_q <= cfg_wr_data;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1.mib_bits      <= mib_bits;
			item_s1.antenna_count <= antenna_count;
			item_s1.tag_present   <= tag_present;
			item_s1.tag_index     <= tag_index;
		end
	end

	// held cell state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// report register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (slot_free) begin
			out_valid_q <= advance && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			out_q <= res;
		end
	end

	assign out_valid      = out_valid_q;
	assign kind           = out_q.kind;
	assign ant_ports      = out_q.ant_ports;
	assign bandwidth_rb   = out_q.bandwidth_rb;
	assign phich_long     = out_q.phich_long;
	assign phich_res_code = out_q.phich_res_code;
	assign frame_number   = out_q.frame_number;
	assign last           = out_q.last;

	a_state_report_no_frame: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_q.kind == KIND_STATE) |-> out_q.frame_number == '0)
		else $error("state report carries a frame number");

	a_frame_report_has_frame: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_q.kind == KIND_FRAME) |-> state_q.frame_valid)
		else $error("frame report without a held frame");

	a_report_has_cell: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> state_q.cell_valid || (out_q.kind == KIND_FRAME))
		else $error("state report without a valid cell state");

	a_accept_clears_count: assert property (@(posedge clk) disable iff (!arst_n)
		advance && emit && (res.kind == KIND_STATE) |=> state_q.unchanged_count == '0)
		else $error("state acceptance did not clear the unchanged count");

	a_no_emit_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |=> out_valid_q && $stable(out_q))
		else $error("pending report word was overwritten");

endmodule
`default_nettype wire

// ----- sv/lmft_step.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lmft_step
// Decodes one registered MIB word against the held cell state and yields the
// next state and the report word, if any.
// ----------------------------------------------------------------------------
module lmft_step (
	input  var lmft_pkg::item_t                   item,
	input  var lmft_pkg::cell_state_t             cur,
	input  wire logic [lmft_pkg::CountW-1:0]      accept_limit,
	output lmft_pkg::cell_state_t                 nxt,
	output logic                                  emit,
	output lmft_pkg::result_t                     res
);
	import lmft_pkg::*;

	logic [RbW-1:0]  bw;
	logic            dur;
	logic [ResW-1:0] pres;
	logic            changed;
	logic            accept;
	logic [1:0]      sfn_lsb;
	logic [SfnW-1:0] sfn;
	logic            emit_frame;

	always_comb begin
		bw      = rb_lookup(item.mib_bits[23:21]);
		dur     = item.mib_bits[20];
		pres    = item.mib_bits[19:18];
		changed = !cur.cell_valid || (bw != cur.bandwidth) ||
			(dur != cur.phich_long) || (pres != cur.phich_grp);
		accept  = changed && (cur.unchanged_count < accept_limit);
		sfn_lsb = item.tag_present ? item.tag_index[3:2] : 2'b00;
		sfn     = {item.mib_bits[17:10], sfn_lsb};
	end

	always_comb begin
		nxt        = cur;
		emit_frame = 1'b0;
		if (item.antenna_count != '0) begin
			nxt.ant_ports = item.antenna_count;
			if (accept) begin
				nxt.bandwidth       = bw;
				nxt.phich_long      = dur;
				nxt.phich_grp       = pres;
				nxt.cell_valid      = 1'b1;
				nxt.unchanged_count = '0;
			end else if (cur.unchanged_count != CountMax) begin
				nxt.unchanged_count = cur.unchanged_count + CountW'(1);
			end
			if (!(changed && cur.frame_valid)) begin
				if (!cur.frame_valid) begin
					nxt.frame_valid = 1'b1;
					nxt.frame       = sfn;
				end else if (sfn != cur.frame) begin
					nxt.frame  = sfn;
					emit_frame = 1'b1;
				end
			end
		end
	end

	always_comb begin
		emit               = (item.antenna_count != '0) && (accept || emit_frame);
		res.kind           = emit_frame ? KIND_FRAME : KIND_STATE;
		res.ant_ports      = nxt.ant_ports;
		res.bandwidth_rb   = nxt.bandwidth;
		res.phich_long     = nxt.phich_long;
		res.phich_res_code = nxt.phich_grp;
		res.frame_number   = emit_frame ? nxt.frame : '0;
		res.last           = 1'b1;
	end

endmodule
`default_nettype wire
